FILE: hdl/pgt_pkg.sv
package pgt_pkg;

    localparam int DEF_MAX_COLUMNS = 32;
    localparam int DEF_MAX_ROWS    = 32;

    localparam int MODE_W     = 2;
    localparam int COORD_W    = 5;
    localparam int TILE_W     = 8;
    localparam int OFFS_W     = 7;
    localparam int SIZE_W     = 6;
    localparam int KIND_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    // Wide enough to hold the largest grid limit of 63.
    localparam int LIMIT_W    = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 2'd0,
        MODE_WALK  = 2'd1,
        MODE_PLOT  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X  = 3'd0,
        CFG_OFFSET_Y  = 3'd1,
        CFG_COLUMNS   = 3'd2,
        CFG_ROWS      = 3'd3,
        CFG_TILE_KIND = 3'd4
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic load_start;
        logic load_walk;
        logic plot;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic at_point;
        logic step_last;
    } t_dp_stat;

endpackage

FILE: hdl/pgt_ctrl.sv
module pgt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_mode,
    output logic               o_ready,
    input  pgt_pkg::t_dp_stat  i_stat,
    output pgt_pkg::t_dp_cmd   o_cmd
);
    import pgt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                // A walk to the current position produces no tiles.
                if (accept && (t_mode'(i_mode) == MODE_WALK) && !i_stat.at_point) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_stat.out_free && i_stat.step_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = i_stat.out_free;
                if (accept) begin
                    case (t_mode'(i_mode))
                        MODE_START: o_cmd.load_start = 1'b1;
                        MODE_WALK:  o_cmd.load_walk  = 1'b1;
                        MODE_PLOT:  o_cmd.plot       = 1'b1;
                        default:    o_cmd            = '0;
                    endcase
                end
            end
            ST_WALK: begin
                o_cmd.step = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: hdl/pgt_datapath.sv
module pgt_datapath #(
    parameter int MAX_COLUMNS = pgt_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = pgt_pkg::DEF_MAX_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [pgt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pgt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [pgt_pkg::COORD_W-1:0]      i_point_x,
    input  logic [pgt_pkg::COORD_W-1:0]      i_point_y,
    input  pgt_pkg::t_dp_cmd                 i_cmd,
    output pgt_pkg::t_dp_stat                o_stat,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic signed [pgt_pkg::TILE_W-1:0] o_tile_x,
    output logic signed [pgt_pkg::TILE_W-1:0] o_tile_y,
    output logic                             o_in_bounds,
    output logic [pgt_pkg::KIND_W-1:0]       o_tile_value,
    output logic                             o_last
);
    import pgt_pkg::*;

    localparam int PROD_W = 2 * COORD_W;
    localparam int DIFF_W = PROD_W + 1;

    logic signed [OFFS_W-1:0] r_offset_x;
    logic signed [OFFS_W-1:0] r_offset_y;
    logic [SIZE_W-1:0]        r_columns;
    logic [SIZE_W-1:0]        r_rows;
    logic [KIND_W-1:0]        r_tile_kind;

    logic [COORD_W-1:0] r_cur_x, r_cur_y;
    logic [COORD_W-1:0] r_span_x, r_span_y;
    logic [COORD_W-1:0] r_tgt_x, r_tgt_y;

    logic r_out_valid;

    logic                     dx_ne, dy_ne;
    logic [COORD_W-1:0]       rem_x, rem_y;
    logic [COORD_W-1:0]       pt_span_x, pt_span_y;
    logic [PROD_W-1:0]        prod_x, prod_y;
    logic signed [DIFF_W-1:0] diff;
    logic                     move_x, move_y;
    logic [COORD_W-1:0]       nx, ny;
    logic [COORD_W-1:0]       ex, ey;
    logic signed [TILE_W-1:0] tx, ty;
    logic [LIMIT_W-1:0]       cols_lim, rows_lim;
    logic                     inb;
    logic                     load_out;
    logic                     out_free;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x  <= '0;
            r_offset_y  <= '0;
            r_columns   <= SIZE_W'(32);
            r_rows      <= SIZE_W'(32);
            r_tile_kind <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_OFFSET_X:  r_offset_x  <= i_cfg_data[OFFS_W-1:0];
                CFG_OFFSET_Y:  r_offset_y  <= i_cfg_data[OFFS_W-1:0];
                CFG_COLUMNS:   r_columns   <= i_cfg_data[SIZE_W-1:0];
                CFG_ROWS:      r_rows      <= i_cfg_data[SIZE_W-1:0];
                CFG_TILE_KIND: r_tile_kind <= i_cfg_data[KIND_W-1:0];
                default:       r_tile_kind <= r_tile_kind;
            endcase
        end
    end

    // Step decision: remaining distance against the segment spans.
    always_comb begin
        dx_ne  = (r_cur_x != r_tgt_x);
        dy_ne  = (r_cur_y != r_tgt_y);
        rem_x  = (r_cur_x > r_tgt_x) ? (r_cur_x - r_tgt_x) : (r_tgt_x - r_cur_x);
        rem_y  = (r_cur_y > r_tgt_y) ? (r_cur_y - r_tgt_y) : (r_tgt_y - r_cur_y);
        prod_x = PROD_W'(rem_x) * PROD_W'(r_span_y);
        prod_y = PROD_W'(rem_y) * PROD_W'(r_span_x);
        diff   = $signed({1'b0, prod_x}) - $signed({1'b0, prod_y});
        move_x = dx_ne && (!dy_ne || !diff[DIFF_W-1]);
        move_y = dy_ne && (!dx_ne || diff[DIFF_W-1] || (diff == '0));
        nx = r_cur_x;
        ny = r_cur_y;
        if (move_x) begin
            nx = (r_cur_x < r_tgt_x) ? (r_cur_x + 1'b1) : (r_cur_x - 1'b1);
        end
        if (move_y) begin
            ny = (r_cur_y < r_tgt_y) ? (r_cur_y + 1'b1) : (r_cur_y - 1'b1);
        end
        pt_span_x = (r_cur_x > i_point_x) ? (r_cur_x - i_point_x) : (i_point_x - r_cur_x);
        pt_span_y = (r_cur_y > i_point_y) ? (r_cur_y - i_point_y) : (i_point_y - r_cur_y);
    end

    // Tile coordinate, offset and bounds check for the emitted tile.
    always_comb begin
        ex = i_cmd.plot ? i_point_x : nx;
        ey = i_cmd.plot ? i_point_y : ny;
        tx = $signed({{(TILE_W-COORD_W){1'b0}}, ex})
           + $signed({{(TILE_W-OFFS_W){r_offset_x[OFFS_W-1]}}, r_offset_x});
        ty = $signed({{(TILE_W-COORD_W){1'b0}}, ey})
           + $signed({{(TILE_W-OFFS_W){r_offset_y[OFFS_W-1]}}, r_offset_y});
        cols_lim = (LIMIT_W'(r_columns) < LIMIT_W'(MAX_COLUMNS)) ?
                   LIMIT_W'(r_columns) : LIMIT_W'(MAX_COLUMNS);
        rows_lim = (LIMIT_W'(r_rows) < LIMIT_W'(MAX_ROWS)) ?
                   LIMIT_W'(r_rows) : LIMIT_W'(MAX_ROWS);
        inb = !tx[TILE_W-1] && !ty[TILE_W-1]
           && (LIMIT_W'(tx[TILE_W-2:0]) < cols_lim)
           && (LIMIT_W'(ty[TILE_W-2:0]) < rows_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_span_x <= '0;
            r_span_y <= '0;
        end else if (i_cmd.load_start) begin
            r_cur_x <= i_point_x;
            r_cur_y <= i_point_y;
        end else if (i_cmd.load_walk) begin
            r_span_x <= pt_span_x;
            r_span_y <= pt_span_y;
        end else if (i_cmd.step) begin
            r_cur_x <= nx;
            r_cur_y <= ny;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_walk) begin
            r_tgt_x <= i_point_x;
            r_tgt_y <= i_point_y;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign load_out = i_cmd.plot || i_cmd.step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_tile_x     <= tx;
            o_tile_y     <= ty;
            o_in_bounds  <= inb;
            o_tile_value <= r_tile_kind;
            o_last       <= i_cmd.plot || ((nx == r_tgt_x) && (ny == r_tgt_y));
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_stat.out_free  = out_free;
    assign o_stat.at_point  = (i_point_x == r_cur_x) && (i_point_y == r_cur_y);
    assign o_stat.step_last = (nx == r_tgt_x) && (ny == r_tgt_y);

endmodule

FILE: hdl/polyline_grid_tracer.sv
// Traces a polyline over a tile grid. A start request moves the pen, a walk request
// steps the pen toward its point one tile per cycle while the output is free, sends
// every tile it enters, and a plot request sends one tile without moving the pen.
// A walk request sends between max(|dx|,|dy|) and |dx|+|dy| tiles, at most 62 on
// the full grid. Every request, the one after a walk included, is accepted only
// while the output register is empty or is being read in that cycle, so a stalled
// tile holds off the input. Each tile carries the x and y coordinates with the x
// and y offsets added, the tile kind and a flag that the tile lies within
// min(grid_columns, MAX_COLUMNS) by min(grid_rows, MAX_ROWS); the last tile of a
// request is flagged. Configuration writes are always accepted and must only be made
// while no request is in progress.
module polyline_grid_tracer #(
    parameter int MAX_COLUMNS = pgt_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = pgt_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pgt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pgt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pgt_pkg::MODE_W-1:0]        i_mode,
    input  logic [pgt_pkg::COORD_W-1:0]       i_point_x,
    input  logic [pgt_pkg::COORD_W-1:0]       i_point_y,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [pgt_pkg::TILE_W-1:0] o_tile_x,
    output logic signed [pgt_pkg::TILE_W-1:0] o_tile_y,
    output logic                              o_in_bounds,
    output logic [pgt_pkg::KIND_W-1:0]        o_tile_value,
    output logic                              o_last
);
    import pgt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    pgt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pgt_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (i_ready),
        .o_out_valid  (o_valid),
        .o_tile_x     (o_tile_x),
        .o_tile_y     (o_tile_y),
        .o_in_bounds  (o_in_bounds),
        .o_tile_value (o_tile_value),
        .o_last       (o_last)
    );

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pgt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_TILES_PER_WALK = 62;
    localparam int HOLD_LEN  = 300;
    localparam int SETTLE    = 8;

    typedef struct packed {
        logic signed [TILE_W-1:0] x;
        logic signed [TILE_W-1:0] y;
        logic                     inb;
        logic [KIND_W-1:0]        value;
        logic                     last;
    } t_tile;

    // Keeps its own pen position and register copies and queues the tiles that
    // every accepted request must produce.
    class tile_ledger;
        t_tile             expected_tiles[$];
        int                mismatches;
        logic [COORD_W-1:0] pen_x, pen_y, span_x, span_y;
        int                off_x, off_y, columns, rows;
        logic [KIND_W-1:0] kind;

        function new();
            mismatches = 0;
            pen_x = '0;
            pen_y = '0;
            span_x = '0;
            span_y = '0;
            off_x = 0;
            off_y = 0;
            columns = 32;
            rows = 32;
            kind = '0;
        endfunction

        function void set_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OFFSET_X:  off_x = $signed(data[OFFS_W-1:0]);
                CFG_OFFSET_Y:  off_y = $signed(data[OFFS_W-1:0]);
                CFG_COLUMNS:   columns = data[SIZE_W-1:0];
                CFG_ROWS:      rows = data[SIZE_W-1:0];
                CFG_TILE_KIND: kind = data[KIND_W-1:0];
                default: ;
            endcase
        endfunction

        function int distance(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        function int approach(int a, int b);
            if (a < b) return a + 1;
            if (a > b) return a - 1;
            return a;
        endfunction

        function void push_tile(int x, int y);
            t_tile t;
            int    tx, ty, cols, nrows;
            tx = x + off_x;
            ty = y + off_y;
            cols = (columns < DEF_MAX_COLUMNS) ? columns : DEF_MAX_COLUMNS;
            nrows = (rows < DEF_MAX_ROWS) ? rows : DEF_MAX_ROWS;
            t.x = tx;
            t.y = ty;
            t.inb = (tx >= 0) && (ty >= 0) && (tx < cols) && (ty < nrows);
            t.value = kind;
            t.last = 1'b0;
            expected_tiles.push_back(t);
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [COORD_W-1:0] px,
                                   logic [COORD_W-1:0] py);
            int cx, cy, tx, ty, d, n;
            tx = px;
            ty = py;
            case (mode)
                MODE_START: begin
                    pen_x = px;
                    pen_y = py;
                end
                MODE_PLOT: begin
                    push_tile(tx, ty);
                    expected_tiles[$].last = 1'b1;
                end
                MODE_WALK: begin
                    cx = pen_x;
                    cy = pen_y;
                    span_x = distance(cx, tx);
                    span_y = distance(cy, ty);
                    n = 0;
                    while ((cx != tx || cy != ty) && n < MAX_TILES_PER_WALK) begin
                        if (cx != tx && cy == ty) begin
                            cx = approach(cx, tx);
                        end else if (cx == tx && cy != ty) begin
                            cy = approach(cy, ty);
                        end else begin
                            // Compare the remaining distance against the segment slope.
                            d = distance(cx, tx) * span_y - distance(cy, ty) * span_x;
                            if (d >= 0) cx = approach(cx, tx);
                            if (d <= 0) cy = approach(cy, ty);
                        end
                        push_tile(cx, cy);
                        n++;
                    end
                    if (n > 0) expected_tiles[$].last = 1'b1;
                    pen_x = cx;
                    pen_y = cy;
                end
                default: ;
            endcase
        endfunction

        function void check_tile(t_tile got);
            t_tile want;
            if (expected_tiles.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected tile x=%0d y=%0d in=%0b value=%0d last=%0b",
                             got.x, got.y, got.inb, got.value, got.last);
                mismatches++;
                return;
            end
            want = expected_tiles.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.inb !== want.inb ||
                got.value !== want.value || got.last !== want.last) begin
                if (mismatches < 10)
                    $display("tile mismatch: expected x=%0d y=%0d in=%0b value=%0d last=%0b, %s",
                             want.x, want.y, want.inb, want.value, want.last,
                             $sformatf("got x=%0d y=%0d in=%0b value=%0d last=%0b",
                                       got.x, got.y, got.inb, got.value, got.last));
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [MODE_W-1:0]        i_mode = '0;
    logic [COORD_W-1:0]       i_point_x = '0;
    logic [COORD_W-1:0]       i_point_y = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [TILE_W-1:0] o_tile_x;
    logic signed [TILE_W-1:0] o_tile_y;
    logic                     o_in_bounds;
    logic [KIND_W-1:0]        o_tile_value;
    logic                     o_last;

    tile_ledger ledger = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    polyline_grid_tracer DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output side: random stalls, plus a long hold-off whenever the token moves.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_LEN;
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            ledger.check_tile('{o_tile_x, o_tile_y, o_in_bounds, o_tile_value, o_last});
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Leaves i_cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.set_register(idx, data);
    endtask

    task automatic set_config(input logic [7:0] ox, oy, cols, nrows, kind);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, nrows);
        write_reg(CFG_TILE_KIND, kind);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic offer_request(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] px,
                                 input logic [COORD_W-1:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_point_x <= px;
        i_point_y <= py;
        do @(posedge i_clk); while (!o_ready);
        ledger.note_request(mode, px, py);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (ledger.expected_tiles.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic directed_requests();
        offer_request(MODE_START, 5'd0, 5'd0);
        offer_request(MODE_WALK, 5'd31, 5'd31);
        offer_request(MODE_WALK, 5'd0, 5'd31);
        offer_request(MODE_WALK, 5'd0, 5'd0);
        offer_request(MODE_WALK, 5'd0, 5'd0);
        offer_request(MODE_WALK, 5'd31, 5'd0);
        offer_request(MODE_WALK, 5'd0, 5'd31);
        offer_request(MODE_START, 5'd3, 5'd5);
        offer_request(MODE_WALK, 5'd17, 5'd28);
        offer_request(MODE_WALK, 5'd29, 5'd2);
        offer_request(MODE_PLOT, 5'd31, 5'd31);
        offer_request(MODE_PLOT, 5'd0, 5'd0);
        offer_request(MODE_UNUSED, 5'd31, 5'd31);
        offer_request(MODE_START, 5'd31, 5'd31);
        offer_request(MODE_WALK, 5'd0, 5'd0);
        offer_request(MODE_WALK, 5'd1, 5'd31);
        offer_request(MODE_PLOT, 5'd16, 5'd15);
        offer_request(MODE_UNUSED, 5'd0, 5'd0);
        offer_request(MODE_START, 5'd10, 5'd10);
        offer_request(MODE_WALK, 5'd10, 5'd10);
        offer_request(MODE_WALK, 5'd12, 5'd3);
    endtask

    // Mostly walks with short or full-range segments; some starts, plots and the
    // unused mode as noise. Unused-mode requests do not count toward the total.
    task automatic run_phase(input logic [7:0] ox, oy, cols, nrows, kind,
                             input int send_pct, recv_pct, count, input bit with_hold);
        int done, pick, t;
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] px, py;
        bit held;
        done = 0;
        held = 0;
        set_config(ox, oy, cols, nrows, kind);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
        while (done < count) begin
            pick = $urandom_range(99);
            px = $urandom;
            py = $urandom;
            if (pick < 10) begin
                mode = MODE_START;
            end else if (pick < 18) begin
                mode = MODE_PLOT;
            end else if (pick < 21) begin
                mode = MODE_UNUSED;
            end else begin
                mode = MODE_WALK;
                if (pick < 60) begin
                    t = int'(ledger.pen_x) + $urandom_range(8) - 4;
                    px = (t < 0) ? 5'd0 : (t > 31) ? 5'd31 : t;
                    t = int'(ledger.pen_y) + $urandom_range(8) - 4;
                    py = (t < 0) ? 5'd0 : (t > 31) ? 5'd31 : t;
                end
            end
            if (with_hold && !held && done == 10) begin
                hold_token <= hold_token + 1;
                held = 1;
            end
            offer_request(mode, px, py);
            if (mode != MODE_UNUSED) done++;
        end
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_requests();
        drain_results();

        // Most negative x offset, zero columns so nothing is in bounds.
        run_phase(8'h40, 8'h3F, 8'd0, 8'd63, 8'd255, 0, 0, 25, 0);
        run_phase($urandom, $urandom, 8'd1, 8'd1, $urandom, 75, 0, 35, 0);
        run_phase(8'h80, 8'hC0, 8'd32, 8'd32, 8'h5A, 0, 75, 40, 1);
        run_phase($urandom, $urandom, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom, 28, 28, 55, 0);
        run_phase(8'hBF, 8'hFF, 8'd33, 8'd31, $urandom, 75, 75, 50, 0);

        if (ledger.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
